@@ hdl/tensor_dtype_to_f32_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the element converter
// Shared property wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TENSOR_DTYPE_TO_F32_CORE_MACROS_SVH
`define TENSOR_DTYPE_TO_F32_CORE_MACROS_SVH

// implication checked every cycle outside reset
`define TDF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// follow-on check in the next cycle
`define TDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/tdf_pkg.sv @@
// ----------------------------------------------------------------------------
// tdf_pkg
// Source format codes and field widths for the element converter.
// ----------------------------------------------------------------------------
package tdf_pkg;
  typedef enum logic [1:0] {
    FMT_SINGLE = 2'd0,
    FMT_BF16   = 2'd1,
    FMT_HALF   = 2'd2,
    FMT_DOUBLE = 2'd3
  } fmt_t;

  localparam int RAW_W = 64;
  localparam int SGL_W = 32;
  localparam logic [31:0] SGL_INF  = 32'h7F80_0000;
  localparam logic [31:0] SGL_QNAN = 32'h7FC0_0000;
endpackage

@@ hdl/tdf_convert.sv @@
// ----------------------------------------------------------------------------
// tdf_convert
// Combinational conversion of one raw element to single-precision bits.
// ----------------------------------------------------------------------------
module tdf_convert
  import tdf_pkg::*;
(
  input  fmt_t               fmt,
  input  logic [RAW_W-1:0]   raw,
  output logic [SGL_W-1:0]   res
);

  logic [31:0] half_res, dbl_res;

  // half widening
  logic [4:0]  h_ex;
  logic [9:0]  h_man;
  logic [3:0]  h_p;
  logic [7:0]  h_exp;
  logic [22:0] h_frac;

  always_comb begin
    h_ex  = raw[14:10];
    h_man = raw[9:0];
    h_p   = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (h_man[i]) h_p = 4'(i);
    end
    h_exp  = 8'(h_p) + 8'd103;
    h_frac = 23'({h_man, 13'd0} << (4'd10 - h_p));
    if (h_ex == 5'd0) begin
      if (h_man == 10'd0) half_res = {raw[15], 31'd0};
      else                half_res = {raw[15], h_exp, h_frac};
    end else if (h_ex == 5'h1F) begin
      half_res = {raw[15], 8'hFF, h_man, 13'd0};
    end else begin
      half_res = {raw[15], 8'(h_ex) + 8'd112, h_man, 13'd0};
    end
  end

  // double narrowing, round to nearest even
  logic [10:0] d_ex;
  logic [51:0] d_man;
  logic [52:0] d_sig;
  logic [23:0] n_q;
  logic        n_up;
  logic [31:0] n_bits;
  logic [5:0]  s_sh;
  logic [53:0] s_ext;
  logic [53:0] s_q;
  logic [53:0] s_mask;
  logic [53:0] s_rem;
  logic [53:0] s_half;
  logic        s_up;

  always_comb begin
    d_ex   = raw[62:52];
    d_man  = raw[51:0];
    d_sig  = {1'b1, d_man};
    n_q    = d_sig[52:29];
    n_up   = d_sig[28] & ((d_sig[27:0] != 28'd0) | n_q[0]);
    n_bits = ({1'b0, 8'(d_ex - 11'd897), 23'd0}) + 32'(n_q) + 32'(n_up);
    s_sh   = 6'(11'd926 - d_ex);
    s_ext  = {1'b0, d_sig};
    s_q    = s_ext >> s_sh;
    s_mask = (54'd1 << s_sh) - 54'd1;
    s_rem  = s_ext & s_mask;
    s_half = 54'd1 << (s_sh - 6'd1);
    s_up   = (s_rem > s_half) | ((s_rem == s_half) & s_q[0]);
    if (d_ex == 11'h7FF) begin
      if (d_man == 52'd0) dbl_res = {raw[63], 31'd0} | SGL_INF;
      else                dbl_res = {raw[63], 31'd0} | SGL_QNAN | 32'(d_man[51:29]);
    end else if (d_ex == 11'd0) begin
      dbl_res = {raw[63], 31'd0};
    end else if (d_ex >= 11'd1151) begin
      dbl_res = {raw[63], 31'd0} | SGL_INF;
    end else if (d_ex >= 11'd897) begin
      if (n_bits >= SGL_INF) dbl_res = {raw[63], 31'd0} | SGL_INF;
      else                   dbl_res = {raw[63], n_bits[30:0]};
    end else if (d_ex < 11'd872) begin
      dbl_res = {raw[63], 31'd0};
    end else begin
      dbl_res = {raw[63], 31'(s_q + 54'(s_up))};
    end
  end

  always_comb begin
    case (fmt)
      FMT_SINGLE: res = raw[31:0];
      FMT_BF16:   res = {raw[15:0], 16'd0};
      FMT_HALF:   res = half_res;
      FMT_DOUBLE: res = dbl_res;
      default:    res = raw[31:0];
    endcase
  end

endmodule

@@ hdl/tensor_dtype_to_f32_core.sv @@
// ----------------------------------------------------------------------------
// tensor_dtype_to_f32_core
// Raw tensor element (single, bfloat16, half, double) to single precision.
// ----------------------------------------------------------------------------
// One element per cycle; busy stays low. Each beat taken on start is
// registered at the input, converted in one pass and registered again:
// out_valid follows start through in_vld_r and out_vld_r and is high for
// exactly one cycle per beat. The receiver cannot stall. cfg_ writes
// should be made with no beat in flight.
`include "tensor_dtype_to_f32_core_macros.svh"
module tensor_dtype_to_f32_core
  import tdf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [RAW_W-1:0]  in_raw_word,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_source_format,
  output logic              out_valid,
  output logic [SGL_W-1:0]  out_single_bits
);

  fmt_t             fmt_r;
  logic             in_vld_r;
  logic [RAW_W-1:0] in_raw_r;
  logic [SGL_W-1:0] res_nxt, res_r;
  logic             out_vld_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r     <= FMT_SINGLE;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) fmt_r <= fmt_t'(cfg_source_format);
      in_vld_r  <= start;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) in_raw_r <= in_raw_word;
    if (in_vld_r) res_r <= res_nxt;
  end

  tdf_convert u_conv (
    .fmt (fmt_r),
    .raw (in_raw_r),
    .res (res_nxt)
  );

  assign out_valid       = out_vld_r;
  assign out_single_bits = res_r;

  `TDF_ASSERT_NEXT(a_flow, start && !busy, in_vld_r, "accepted beat lost")
  `TDF_ASSERT_NEXT(a_out, in_vld_r, out_valid, "result beat lost")
  `TDF_ASSERT_IMP(a_bf16, in_vld_r && fmt_r == FMT_BF16,
                  res_nxt[15:0] == 16'd0, "bf16 low half not zero")

endmodule
